[hdl/riex_pkg.sv]
// package: opcodes and shared types for the execute unit
`default_nettype none
package riex_pkg;

  localparam int XLEN = 64;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_EXITI = 5'd1, OP_SYSCALL = 5'd2, OP_ADD = 5'd3, OP_ADDI = 5'd4,
    OP_SUB = 5'd5, OP_MULT = 5'd6, OP_DIV = 5'd7, OP_MOD = 5'd8, OP_LW = 5'd9,
    OP_SW = 5'd10, OP_LUI = 5'd11, OP_AND = 5'd12, OP_ANDI = 5'd13, OP_OR = 5'd14,
    OP_ORI = 5'd15, OP_XOR = 5'd16, OP_NOR = 5'd17, OP_SLT = 5'd18, OP_SLTI = 5'd19,
    OP_SLLI = 5'd20, OP_SRLI = 5'd21, OP_SLL = 5'd22, OP_SRL = 5'd23, OP_BEQ = 5'd24,
    OP_BEQL = 5'd25, OP_BNE = 5'd26, OP_BNEL = 5'd27, OP_J = 5'd28, OP_JR = 5'd29,
    OP_JAL = 5'd30, OP_ILLEGAL = 5'd31
  } op_t;

  // request to the iterative multiply/divide unit
  typedef struct packed {
    logic            start;
    logic            is_div;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
  } md_req_t;

  // response of the iterative multiply/divide unit
  typedef struct packed {
    logic            done;
    logic [XLEN-1:0] prod;
    logic [XLEN-1:0] quot;
    logic [XLEN-1:0] rem;
  } md_rsp_t;

endpackage
`default_nettype wire

[hdl/riex_muldiv.sv]
// shared iterative unit: shift-add multiply and restoring divide, one bit per cycle
`default_nettype none
module riex_muldiv
  import riex_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire md_req_t req,
  output md_rsp_t      rsp
);

  logic            busy;
  logic            done;
  logic            is_div;
  logic [6:0]      count;
  logic [XLEN-1:0] acc;
  logic [XLEN-1:0] opa;
  logic [XLEN-1:0] opb;
  logic [XLEN:0]   trial;

  // restoring divide trial: shifted remainder minus divisor
  always_comb begin
    trial = {acc, opa[XLEN-1]} - {1'b0, opb};
  end

  // iteration sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        count  <= 7'(XLEN);
        acc    <= '0;
        opa    <= req.a;
        opb    <= req.b;
      end else if (busy) begin
        if (is_div) begin
          if (!trial[XLEN]) begin
            acc <= trial[XLEN-1:0];
            opa <= {opa[XLEN-2:0], 1'b1};
          end else begin
            acc <= {acc[XLEN-2:0], opa[XLEN-1]};
            opa <= {opa[XLEN-2:0], 1'b0};
          end
        end else begin
          // low product bits only: add multiplicand when low multiplier bit set
          if (opb[0]) acc <= acc + opa;
          opa <= {opa[XLEN-2:0], 1'b0};
          opb <= {1'b0, opb[XLEN-1:1]};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;
  assign rsp.quot = opa;
  assign rsp.rem  = acc;

endmodule
`default_nettype wire

[hdl/risc_instruction_execute_unit.sv]
// top level: sequential execute unit with register file and data memory
// channel  | dir | handshake               | content
// s_axis   | in  | s_axis_tvalid/tready    | decoded instruction
// m_axis   | out | m_axis_tvalid/tready    | execution result
// cfg      | in  | cfg_valid/cfg_ready     | start_address
// an instruction with no stall goes through accept, three operand reads from the
// register file (one port per cycle), execute with write back, result; the next one is
// taken the cycle after the result leaves. loads add S_LOAD, S_LOAD2 for the registered
// memory read, jal and divide by zero add S_JAL, mult, div and mod wait in S_MD for the
// shared unit. after reset a clearing pass writes zero to every data memory word while
// no instruction is taken. a stalled result holds its register until taken.
`default_nettype none
module risc_instruction_execute_unit
  import riex_pkg::*;
#(
  parameter int NUM_REGS   = 32,
  parameter int RETURN_REG = 31,
  parameter int DMEM_WORDS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // func[4:0], dest_reg[9:5], src_a_reg[14:10], src_b_reg[19:15], imm[51:20], zero
  input  wire logic [55:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // next_ip[63:0], reg_written[64], reg_index[69:65], reg_value[133:70],
  // exit_request[134], exit_code[166:135], syscall_request[167],
  // bad_opcode[168], div_by_zero[169], zero
  output logic [175:0]      m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data
);

  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
  localparam logic [RW-1:0] RET_IDX = RW'(RETURN_REG % NUM_REGS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_D, S_EXEC, S_MD, S_LOAD, S_LOAD2, S_JAL, S_OUT
  } state_t;

  state_t          state;
  logic [XLEN-1:0] pc;
  logic [AW-1:0]   clr_addr;

  // latched instruction
  op_t             op;
  logic [RW-1:0]   rd, rb;
  logic [XLEN-1:0] imm;
  logic [31:0]     imm32;
  logic [XLEN-1:0] a, b, d;

  // register file and memory
  logic [XLEN-1:0] regs [NUM_REGS];
  logic [XLEN-1:0] dmem [DMEM_WORDS];
  logic [XLEN-1:0] rf_q;
  logic [XLEN-1:0] mem_q;

  // result fields
  logic [XLEN-1:0] next_ip, reg_value;
  logic            reg_written, exit_request, syscall_request, bad_opcode, div_by_zero;
  logic [4:0]      reg_index;
  logic [31:0]     exit_code;

  md_req_t         md_req;
  md_rsp_t         md_rsp;

  riex_muldiv u_md (.clk(clk), .rst(rst), .req(md_req), .rsp(md_rsp));

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = (state == S_IDLE) || (state == S_CLEAR);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {6'd0, div_by_zero, bad_opcode, syscall_request, exit_code,
                          exit_request, reg_value, reg_index, reg_written, next_ip};

  // register read address follows the operand sequence
  logic [RW-1:0]   rf_raddr;
  always_comb begin
    unique case (state)
      S_IDLE:  rf_raddr = RW'(s_axis_tdata[14:10] % NUM_REGS);
      S_RD_A:  rf_raddr = rb;
      S_RD_B:  rf_raddr = rd;
      default: rf_raddr = rd;
    endcase
  end

  // datapath operands and ALU
  logic [XLEN-1:0] alu;
  logic            alu_wr;
  logic [XLEN-1:0] a_imm;
  always_comb begin
    a_imm  = a + imm;
    alu    = '0;
    alu_wr = 1'b1;
    unique case (op)
      OP_ADD:  alu = a + b;
      OP_ADDI: alu = a_imm;
      OP_SUB:  alu = a - b;
      OP_LUI:  alu = {imm[31:0], 32'd0};
      OP_AND:  alu = a & b;
      OP_ANDI: alu = a & imm;
      OP_OR:   alu = a | b;
      OP_ORI:  alu = a | imm;
      OP_XOR:  alu = a ^ b;
      OP_NOR:  alu = ~(a | b);
      OP_SLT:  alu = {63'd0, a < b};
      OP_SLTI: alu = {63'd0, a < imm};
      OP_SLLI: alu = a << imm[5:0];
      OP_SRLI: alu = a >> imm[5:0];
      OP_SLL:  alu = a << b[5:0];
      OP_SRL:  alu = a >> b[5:0];
      default: alu_wr = 1'b0;
    endcase
  end

  logic [XLEN-1:0] pc_adv;
  assign pc_adv = pc + XLEN'(8);

  // divide-by-zero writes all ones to the destination
  logic dz_wr;
  assign dz_wr = (state == S_EXEC) && (op == OP_DIV || op == OP_MOD) && (b == '0);

  // jal target comes from rd, which holds the link value when rd is the return register
  logic [XLEN-1:0] jal_src;
  assign jal_src = (rd == RET_IDX) ? reg_value : rf_q;

  // register file port and memory ports
  logic            rf_we;
  logic [RW-1:0]   rf_waddr;
  logic [XLEN-1:0] rf_wdata;
  always_ff @(posedge clk) begin
    if (rf_we) regs[rf_waddr] <= rf_wdata;
    rf_q <= regs[rf_raddr];
  end

  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [XLEN-1:0] mem_wdata;
  always_ff @(posedge clk) begin
    if (mem_we) dmem[mem_addr] <= mem_wdata;
    mem_q <= dmem[mem_addr];
  end

  logic [XLEN-1:0] mem_byte;
  always_comb begin
    mem_byte  = (op == OP_SW) ? d + imm : a_imm;
    mem_we    = 1'b0;
    mem_addr  = AW'((mem_byte >> 3) % DMEM_WORDS);
    mem_wdata = a;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (state == S_EXEC && op == OP_SW) begin
      mem_we = 1'b1;
    end
  end

  // register write: alu/link/divide-by-zero in exec, md result, load, or reset clear of regs
  logic [RW:0]     rclr;
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rd;
    rf_wdata = alu;
    if (state == S_CLEAR) begin
      rf_we    = !rclr[RW];
      rf_waddr = rclr[RW-1:0];
      rf_wdata = '0;
    end else if (state == S_EXEC) begin
      if (alu_wr) begin
        rf_we = 1'b1;
      end else if ((op == OP_BEQL && d == a) || (op == OP_BNEL && d != a)
                   || op == OP_JAL) begin
        rf_we    = 1'b1;
        rf_waddr = RET_IDX;
        rf_wdata = pc_adv;
      end else if (dz_wr) begin
        rf_we    = 1'b1;
        rf_wdata = '1;
      end
    end else if (state == S_MD && md_rsp.done) begin
      rf_we    = 1'b1;
      rf_wdata = (op == OP_MULT) ? md_rsp.prod : (op == OP_DIV) ? md_rsp.quot : md_rsp.rem;
    end else if (state == S_LOAD2) begin
      rf_we    = 1'b1;
      rf_wdata = mem_q;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      pc       <= '0;
      clr_addr <= '0;
      rclr     <= '0;
      md_req.start <= 1'b0;
    end else begin
      md_req.start <= 1'b0;
      if (cfg_valid && cfg_ready) pc <= {32'd0, cfg_data};
      unique case (state)
        S_CLEAR: begin
          if (!rclr[RW]) rclr <= rclr + 1'b1;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DMEM_WORDS - 1) && rclr[RW]) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= op_t'(s_axis_tdata[4:0]);
            rd    <= RW'(s_axis_tdata[9:5] % NUM_REGS);
            rb    <= RW'(s_axis_tdata[19:15] % NUM_REGS);
            imm32 <= s_axis_tdata[51:20];
            imm   <= {{32{s_axis_tdata[51]}}, s_axis_tdata[51:20]};
            state <= S_RD_A;
          end
        end
        S_RD_A: begin a <= rf_q; state <= S_RD_B; end
        S_RD_B: begin b <= rf_q; state <= S_RD_D; end
        S_RD_D: begin d <= rf_q; state <= S_EXEC; end
        S_EXEC: begin
          next_ip         <= pc_adv;
          pc              <= pc_adv;
          reg_written     <= alu_wr;
          reg_index       <= alu_wr ? 5'(rd) : 5'd0;
          reg_value       <= alu_wr ? alu : '0;
          exit_request    <= (op == OP_EXITI);
          exit_code       <= (op == OP_EXITI) ? imm32 : 32'd0;
          syscall_request <= (op == OP_SYSCALL);
          bad_opcode      <= (op == OP_ILLEGAL);
          div_by_zero     <= 1'b0;
          state           <= S_OUT;
          priority case (op)
            OP_MULT, OP_DIV, OP_MOD: begin
              reg_written <= 1'b1;
              reg_index   <= 5'(rd);
              if (op != OP_MULT && b == '0) begin
                div_by_zero <= 1'b1;
                reg_value   <= '1;
                state       <= S_JAL;
              end else begin
                md_req.start  <= 1'b1;
                md_req.is_div <= (op != OP_MULT);
                md_req.a      <= a;
                md_req.b      <= b;
                state         <= S_MD;
              end
            end
            OP_LW: begin
              reg_written <= 1'b1;
              reg_index   <= 5'(rd);
              state       <= S_LOAD;
            end
            OP_BEQ, OP_BEQL, OP_BNE, OP_BNEL: begin
              if ((op == OP_BEQ || op == OP_BEQL) == (d == a)) begin
                next_ip <= pc_adv + {imm[XLEN-4:0], 3'd0};
                pc      <= pc_adv + {imm[XLEN-4:0], 3'd0};
                if (op == OP_BEQL || op == OP_BNEL) begin
                  reg_written <= 1'b1;
                  reg_index   <= 5'(RET_IDX);
                  reg_value   <= pc_adv;
                end
              end
            end
            OP_J: begin
              next_ip <= {imm[XLEN-4:0], 3'd0};
              pc      <= {imm[XLEN-4:0], 3'd0};
            end
            OP_JR: begin
              next_ip <= d;
              pc      <= d;
            end
            OP_JAL: begin
              reg_written <= 1'b1;
              reg_index   <= 5'(RET_IDX);
              reg_value   <= pc_adv;
              state       <= S_JAL;
            end
            default: ;
          endcase
        end
        S_MD: begin
          if (md_rsp.done) begin
            reg_value <= (op == OP_MULT) ? md_rsp.prod :
                         (op == OP_DIV) ? md_rsp.quot : md_rsp.rem;
            state     <= S_OUT;
          end
        end
        S_LOAD:  state <= S_LOAD2;
        S_LOAD2: begin reg_value <= mem_q; state <= S_OUT; end
        S_JAL: begin
          // jal jumps through rd as seen after the link; divide-by-zero passes through too
          if (op == OP_JAL) begin
            next_ip <= {jal_src[XLEN-4:0], 3'd0};
            pc      <= {jal_src[XLEN-4:0], 3'd0};
          end
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0({exit_request, syscall_request, bad_opcode, div_by_zero}))
    else $error("more than one flag");
  a_dz_write: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && div_by_zero |-> reg_written && reg_value == '1)
    else $error("divide by zero result wrong");
`endif

endmodule
`default_nettype wire
